/* sv/pidc_pkg.sv */
package pidc_pkg;

    // Field and datapath widths
    localparam int MEAS_W     = 16;
    localparam int ERR_W      = 17;
    localparam int DERR_W     = 18;
    localparam int GAIN_W     = 32;
    localparam int LIM_W      = 16;
    localparam int FRAC_W     = 16;
    localparam int DRIVE_W    = 17;
    localparam int PROD_W     = 49;
    localparam int DPROD_W    = 50;
    localparam int INTEG_W    = 33;
    localparam int ISUM_W     = 50;
    localparam int TOTAL_W    = 52;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_VALUE   = 3'd0,
        REG_DEAD_BAND      = 3'd1,
        REG_GAIN_P         = 3'd2,
        REG_GAIN_I         = 3'd3,
        REG_GAIN_D         = 3'd4,
        REG_INTEGRAL_LIMIT = 3'd5,
        REG_MAX_OUTPUT     = 3'd6
    } cfg_reg_t;

    // Register file contents seen by the datapath
    typedef struct packed {
        logic signed [MEAS_W-1:0] target_value;
        logic [LIM_W-1:0]         dead_band;
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic [LIM_W-1:0]         integral_limit;
        logic [LIM_W-1:0]         max_output;
    } cfg_t;

    // Input stage contents handed to the output stage
    typedef struct packed {
        logic                     valid;
        logic signed [ERR_W-1:0]  err;
        logic signed [PROD_W-1:0] p_term;
        logic signed [PROD_W-1:0] i_step;
    } stage_t;

endpackage

/* sv/pid_deadband_integral_output_clamp.sv */
// A transaction accepted into the input stage register moves on to the result
// register, which presents it on the m_ ports.
// Throughput: one transaction per cycle unless m_ready stalls the result register;
// the input register and the result register each hold one item, and the integral,
// previous error and held drive update in the same cycle the result register loads.
// Reset (aresetn, synchronous, active low) clears valids, state and all
// configuration registers to zero.
module pid_deadband_integral_output_clamp
    import pidc_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [MEAS_W-1:0]  s_measure,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [DRIVE_W-1:0] m_drive,
    output logic                      m_in_band
);

    cfg_t   cfg;
    stage_t stage;
    logic   advance;

    pidc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pidc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_measure (s_measure),
        .advance   (advance),
        .stage     (stage)
    );

    pidc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .stage     (stage),
        .advance   (advance),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_drive   (m_drive),
        .m_in_band (m_in_band)
    );

endmodule

/* sv/pidc_cfg.sv */
module pidc_cfg
    import pidc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; ignore unknown indexes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_TARGET_VALUE:   cfg_next.target_value   = $signed(cfg_wdata[MEAS_W-1:0]);
                REG_DEAD_BAND:      cfg_next.dead_band      = cfg_wdata[LIM_W-1:0];
                REG_GAIN_P:         cfg_next.gain_p         = $signed(cfg_wdata);
                REG_GAIN_I:         cfg_next.gain_i         = $signed(cfg_wdata);
                REG_GAIN_D:         cfg_next.gain_d         = $signed(cfg_wdata);
                REG_INTEGRAL_LIMIT: cfg_next.integral_limit = cfg_wdata[LIM_W-1:0];
                REG_MAX_OUTPUT:     cfg_next.max_output     = cfg_wdata[LIM_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/pidc_front.sv */
module pidc_front
    import pidc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cfg_t                     cfg,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [MEAS_W-1:0] s_measure,
    input  logic                     advance,
    output stage_t                   stage
);

    stage_t stage_reg;
    logic signed [ERR_W-1:0]  err_next;
    logic signed [PROD_W-1:0] p_next;
    logic signed [PROD_W-1:0] i_next;

    // Error and the two products that need no state
    always_comb begin
        err_next = ERR_W'(cfg.target_value) - ERR_W'(s_measure);
        p_next   = PROD_W'(cfg.gain_p) * PROD_W'(err_next);
        i_next   = PROD_W'(cfg.gain_i) * PROD_W'(err_next);
    end

    // Take a new transaction when the stage is empty or moving on
    assign s_ready = !stage_reg.valid || advance;

    // Load the stage; only the valid bit needs a reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (s_ready) begin
            stage_reg.valid <= s_valid;
        end
        if (s_valid && s_ready) begin
            stage_reg.err    <= err_next;
            stage_reg.p_term <= p_next;
            stage_reg.i_step <= i_next;
        end
    end

    assign stage = stage_reg;

endmodule

/* sv/pidc_core.sv */
module pidc_core
    import pidc_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cfg_t                      cfg,
    input  stage_t                    stage,
    output logic                      advance,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [DRIVE_W-1:0] m_drive,
    output logic                      m_in_band
);

    logic                       m_valid_reg;
    logic                       in_band_reg;
    logic                       in_band_next;
    logic signed [ERR_W-1:0]    prev_error_reg;
    logic signed [ERR_W-1:0]    prev_error_next;
    logic signed [INTEG_W-1:0]  integral_reg;
    logic signed [INTEG_W-1:0]  integral_next;
    logic signed [DRIVE_W-1:0]  held_reg;
    logic signed [DRIVE_W-1:0]  held_next;

    logic                       upd;
    logic [ERR_W-1:0]           mag;
    logic                       band;
    logic signed [DERR_W-1:0]   derr;
    logic signed [DPROD_W-1:0]  d_term;
    logic signed [INTEG_W-1:0]  ilim;
    logic signed [ISUM_W-1:0]   isum;
    logic signed [INTEG_W-1:0]  iclamp;
    logic signed [INTEG_W-1:0]  olim;
    logic signed [TOTAL_W-1:0]  total;
    logic signed [INTEG_W-1:0]  oclamp;

    // The result register frees up when empty or taken
    assign advance = !m_valid_reg || m_ready;
    assign upd     = advance && stage.valid;

    always_comb begin
        // Deadband test, edge counts as in band
        mag  = stage.err[ERR_W-1] ? ERR_W'(-stage.err) : ERR_W'(stage.err);
        band = mag <= {1'b0, cfg.dead_band};

        // Derivative term
        derr   = DERR_W'(stage.err) - DERR_W'(prev_error_reg);
        d_term = DPROD_W'(cfg.gain_d) * DPROD_W'(derr);

        // Accumulate and clamp the integral
        ilim = $signed({1'b0, cfg.integral_limit, {FRAC_W{1'b0}}});
        isum = ISUM_W'(integral_reg) + ISUM_W'(stage.i_step);
        if (isum > ISUM_W'(ilim)) begin
            iclamp = ilim;
        end else if (isum < -ISUM_W'(ilim)) begin
            iclamp = -ilim;
        end else begin
            iclamp = isum[INTEG_W-1:0];
        end

        // Sum the terms and clamp the output
        olim  = $signed({1'b0, cfg.max_output, {FRAC_W{1'b0}}});
        total = TOTAL_W'(stage.p_term) + TOTAL_W'(iclamp) + TOTAL_W'(d_term);
        if (total > TOTAL_W'(olim)) begin
            oclamp = olim;
        end else if (total < -TOTAL_W'(olim)) begin
            oclamp = -olim;
        end else begin
            oclamp = total[INTEG_W-1:0];
        end

        // Hold integral and drive inside the band; floor drops the fraction
        integral_next   = band ? integral_reg : iclamp;
        held_next       = band ? held_reg : oclamp[INTEG_W-1:FRAC_W];
        prev_error_next = stage.err;
        in_band_next    = band;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            prev_error_reg <= '0;
            integral_reg   <= '0;
            held_reg       <= '0;
            in_band_reg    <= 1'b0;
        end else begin
            if (advance) begin
                m_valid_reg <= stage.valid;
            end
            if (upd) begin
                prev_error_reg <= prev_error_next;
                integral_reg   <= integral_next;
                held_reg       <= held_next;
                in_band_reg    <= in_band_next;
            end
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_drive   = held_reg;
    assign m_in_band = in_band_reg;

`ifndef NO_ASSERTIONS
    a_drive_within_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (upd && !band) |=>
            ((held_reg <= $signed({1'b0, $past(cfg.max_output)})) &&
             (held_reg >= -$signed({1'b0, $past(cfg.max_output)}))))
        else $error("drive outside output clamp");

    a_band_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (upd && band) |=> ($stable(integral_reg) && $stable(held_reg) && in_band_reg))
        else $error("integral or drive changed inside deadband");

    a_prev_error_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        upd |=> (prev_error_reg == $past(stage.err)))
        else $error("previous error not updated");

    a_result_held_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> (m_valid_reg && $stable(held_reg)))
        else $error("result changed while stalled");
`endif

endmodule
